### sv/sequential_list_engine_top_macros.svh
// Assertion macros for the sequential list engine checker.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sle_pkg.sv
// Shared widths, action codes and status codes of the sequential list engine.
package sle_pkg;

    localparam int SLE_CAPACITY = 64;
    localparam int DATA_W       = 32;
    localparam int ACT_W        = 4;
    localparam int POS_W        = 7;
    localparam int STAT_W       = 3;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK  = 4'd0,
        ACT_POP_BACK   = 4'd1,
        ACT_PUSH_FRONT = 4'd2,
        ACT_POP_FRONT  = 4'd3,
        ACT_INSERT     = 4'd4,
        ACT_ERASE      = 4'd5,
        ACT_REMOVE     = 4'd6,
        ACT_MODIFY     = 4'd7,
        ACT_FIND       = 4'd8,
        ACT_READ       = 4'd9
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

endpackage

### sv/sle_req_if.sv
// Request channel: action, position and value with valid/ready handshake.
interface sle_req_if import sle_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

### sv/sle_rsp_if.sv
// Result channel: status, index, count and read value with valid/ready handshake.
interface sle_rsp_if import sle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [IDX_W-1:0]         index;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, output status, output index, output count,
                    output read_value, input ready);
    modport sink   (input valid, input status, input index, input count,
                    input read_value, output ready);
endinterface

### sv/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sle_ram import sle_pkg::*; #(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = SLE_CAPACITY
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/sequential_list_engine_top.sv
// Sequential list engine: packed list of signed 32-bit values kept in one RAM.
//
// Usage: requests enter on i_req (action, position, value) and each yields
// exactly one result on o_rsp (status, index, count, read_value). Both
// channels move an item when valid and ready are high at a rising edge.
// One request is worked at a time; i_req.ready is high only while idle.
// An error or an unused action code goes straight to the result; push_back
// and modify write one RAM word, pop_back and read read one. Shifting
// actions move the elements one at a time, find scans from the front until
// a match or the end of the list, and a remove that matches scans and then
// shifts the elements behind the match down. The single RAM read port moves
// or compares one element per cycle. The input is ready again once the result loads.
// The result sits in an output register, so the next request is accepted
// while a finished result waits; a stalled receiver blocks only the
// completion of the following request.
// Reset clears the element count and the handshake state; the RAM is not
// cleared, since only entries below the count are ever read.
module sequential_list_engine_top import sle_pkg::*; #(
    parameter int CAPACITY = SLE_CAPACITY
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sle_req_if.sink    i_req,
    sle_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRVAL = 7'b0000010,
        S_RDW   = 7'b0000100,
        S_SHUP  = 7'b0001000,
        S_SHDN  = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_at, n_at;
    logic [AW-1:0]     r_wa, n_wa;
    logic              r_rv, n_rv;
    logic              r_wv, n_wv;
    logic              r_first, n_first;
    logic              r_keep, n_keep;
    logic              r_rmv, n_rmv;
    logic              r_grow, n_grow;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_rd, n_rd;
    t_status           r_status, n_status;
    logic [IDX_W-1:0]  r_index, n_index;
    logic              r_ovalid, n_ovalid;
    t_status           r_ostatus;
    logic [IDX_W-1:0]  r_oindex;
    logic [CNT_W-1:0]  r_ocount;
    logic [DATA_W-1:0] r_ord;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              accept;
    logic              out_load;
    logic              full;
    logic              empty;
    logic              match;
    logic [PW-1:0]     pos_x;
    logic [PW-1:0]     cnt_x;
    logic [PW-1:0]     wa_x;
    logic [CW-1:0]     cnt_m1;
    logic [AW-1:0]     last;
    logic [AW-1:0]     pos_a;

    sle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_sle_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept  = i_req.valid && i_req.ready;
    assign full    = (r_count == FULL_CNT);
    assign empty   = (r_count == '0);
    assign match   = (ram_rdata == r_val);
    assign pos_x   = PW'(i_req.position);
    assign cnt_x   = PW'(r_count);
    assign wa_x    = PW'(r_wa);
    assign cnt_m1  = r_count - 1'b1;
    assign last    = cnt_m1[AW-1:0];
    assign pos_a   = pos_x[AW-1:0];

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_at      = r_at;
        n_wa      = r_wa;
        n_rv      = r_rv;
        n_wv      = r_wv;
        n_first   = r_first;
        n_keep    = r_keep;
        n_rmv     = r_rmv;
        n_grow    = r_grow;
        n_val     = r_val;
        n_rd      = r_rd;
        n_status  = r_status;
        n_index   = r_index;
        n_ovalid  = r_ovalid;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_at;
        ram_wdata = r_val;
        ram_raddr = r_ptr;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_val    = i_req.value;
                    n_status = ST_OK;
                    n_index  = i_req.position[IDX_W-1:0];
                    n_rd     = '0;
                    n_grow   = 1'b0;
                    n_keep   = 1'b0;
                    n_rmv    = 1'b0;
                    n_rv     = 1'b1;
                    n_wv     = 1'b0;
                    n_state  = S_DONE;
                    case (i_req.action)
                        ACT_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_at    = r_count[AW-1:0];
                                n_grow  = 1'b1;
                                n_state = S_WRVAL;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ram_raddr = last;
                                n_count   = cnt_m1;
                                n_state   = S_RDW;
                            end
                        end
                        ACT_PUSH_FRONT: begin
                            n_at = '0;
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (empty) begin
                                n_grow  = 1'b1;
                                n_state = S_WRVAL;
                            end else begin
                                n_ptr   = last;
                                n_state = S_SHUP;
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_at    = '0;
                                n_ptr   = '0;
                                n_keep  = 1'b1;
                                n_state = S_SHDN;
                            end
                        end
                        ACT_INSERT: begin
                            n_at = pos_a;
                            if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_x > cnt_x) begin
                                n_status = ST_BADPOS;
                            end else if (pos_x == cnt_x) begin
                                n_grow  = 1'b1;
                                n_state = S_WRVAL;
                            end else begin
                                n_ptr   = last;
                                n_state = S_SHUP;
                            end
                        end
                        ACT_ERASE: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_at    = pos_a;
                                n_ptr   = pos_a;
                                n_state = S_SHDN;
                            end
                        end
                        ACT_REMOVE, ACT_FIND: begin
                            if (empty) begin
                                n_status = ST_NOTFOUND;
                                n_index  = '0;
                            end else begin
                                n_ptr   = '0;
                                n_rmv   = (i_req.action == ACT_REMOVE);
                                n_state = S_SCAN;
                            end
                        end
                        ACT_MODIFY: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_at    = pos_a;
                                n_state = S_WRVAL;
                            end
                        end
                        ACT_READ: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_BADPOS;
                            end else begin
                                ram_raddr = pos_a;
                                n_state   = S_RDW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRVAL: begin
                ram_we    = 1'b1;
                ram_waddr = r_at;
                ram_wdata = r_val;
                if (r_grow) begin
                    n_count = r_count + 1'b1;
                end
                n_state = S_DONE;
            end
            S_RDW: begin
                n_rd    = ram_rdata;
                n_state = S_DONE;
            end
            S_SHUP: begin
                if (r_wv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wa;
                    ram_wdata = ram_rdata;
                end
                if (r_rv) begin
                    ram_raddr = r_ptr;
                    n_wa      = r_ptr + 1'b1;
                    n_wv      = 1'b1;
                    if (r_ptr == r_at) begin
                        n_rv = 1'b0;
                    end else begin
                        n_ptr = r_ptr - 1'b1;
                    end
                end else begin
                    n_wv    = 1'b0;
                    n_grow  = 1'b1;
                    n_state = S_WRVAL;
                end
            end
            S_SHDN: begin
                if (r_wv) begin
                    if (r_first) begin
                        if (r_keep) begin
                            n_rd = ram_rdata;
                        end
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wa;
                        ram_wdata = ram_rdata;
                    end
                end
                if (r_rv) begin
                    ram_raddr = r_ptr;
                    n_wa      = r_ptr - 1'b1;
                    n_first   = (r_ptr == r_at);
                    n_wv      = 1'b1;
                    if (r_ptr == last) begin
                        n_rv = 1'b0;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end else begin
                    n_wv    = 1'b0;
                    n_count = cnt_m1;
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (r_rv) begin
                    ram_raddr = r_ptr;
                    n_wa      = r_ptr;
                    n_wv      = 1'b1;
                    if (r_ptr == last) begin
                        n_rv = 1'b0;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
                if (r_wv && match) begin
                    n_index = wa_x[IDX_W-1:0];
                    if (r_rmv) begin
                        n_at    = r_wa;
                        n_ptr   = r_wa;
                        n_rv    = 1'b1;
                        n_wv    = 1'b0;
                        n_state = S_SHDN;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_wv && !r_rv) begin
                    n_status = ST_NOTFOUND;
                    n_index  = '0;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_at     <= n_at;
        r_wa     <= n_wa;
        r_rv     <= n_rv;
        r_wv     <= n_wv;
        r_first  <= n_first;
        r_keep   <= n_keep;
        r_rmv    <= n_rmv;
        r_grow   <= n_grow;
        r_val    <= n_val;
        r_rd     <= n_rd;
        r_status <= n_status;
        r_index  <= n_index;
        if (out_load) begin
            r_ostatus <= r_status;
            r_oindex  <= r_index;
            r_ocount  <= cnt_x[CNT_W-1:0];
            r_ord     <= r_rd;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_ostatus;
    assign o_rsp.index      = r_oindex;
    assign o_rsp.count      = r_ocount;
    assign o_rsp.read_value = r_ord;

endmodule

### sv/sle_checker.sv
// Port-level checker for the sequential list engine, bound to the top level.
`include "sequential_list_engine_top_macros.svh"

module sle_checker import sle_pkg::*; #(
    parameter int CAPACITY = SLE_CAPACITY
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [IDX_W-1:0]  i_index,
    input logic [CNT_W-1:0]  i_count,
    input logic [DATA_W-1:0] i_read_value
);

    `SLE_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_index) && $stable(i_count) && $stable(i_read_value), "result changed while stalled")
    `SLE_ASSERT_IMPLY(a_err_no_data, i_clk, i_rst_n, i_rsp_valid && (i_status != ST_OK), i_read_value == '0, "failed request returned data")
    `SLE_ASSERT_IMPLY(a_notfound_idx, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_NOTFOUND), i_index == '0, "missing value gave nonzero index")
    `SLE_ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_FULL), i_count == CNT_W'(CAPACITY), "full status with count below capacity")
    `SLE_ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, i_rsp_valid, int'(i_count) <= CAPACITY, "count above capacity")

endmodule

bind sequential_list_engine_top sle_checker #(
    .CAPACITY (CAPACITY)
) u_sle_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_index      (o_rsp.index),
    .i_count      (o_rsp.count),
    .i_read_value (o_rsp.read_value)
);
